@@ design/assert_macros.svh @@
// Assertion macros of the tunnel keepalive monitor, used by tkm_step.
// Depends on nothing; included by tkm_step, which checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every rising clock edge outside reset.
`define TKM_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("%m: condition does not hold");

// When the antecedent holds, the consequent must hold in the same cycle.
`define TKM_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication does not hold");

// When the antecedent holds, the consequent must hold in the next cycle.
`define TKM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle implication does not hold");

`endif

@@ design/tkm_pkg.sv @@
// Types, codes and helper functions of the tunnel keepalive monitor.
// Used by every module and interface of the block; depends on nothing.
package tkm_pkg;

   localparam int unsigned TIME_WIDTH      = 32;
   localparam int unsigned COUNT_WIDTH     = 32;
   localparam int unsigned PERIOD_WIDTH    = 16;
   localparam int unsigned MISS_WIDTH      = 8;
   localparam int unsigned CODE_WIDTH      = 2;
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 16;

   // Register indexes on the configuration channel.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_KEEPALIVE_PERIOD = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RECEIVE_TIMEOUT  = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MISS_LIMIT       = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_RECOVERY_PERIOD  = 3'd3;

   // Register reset values.
   localparam logic [PERIOD_WIDTH-1:0] KEEPALIVE_PERIOD_RESET = 16'd10;
   localparam logic [PERIOD_WIDTH-1:0] RECEIVE_TIMEOUT_RESET  = 16'd30;
   localparam logic [MISS_WIDTH-1:0]   MISS_LIMIT_RESET       = 8'd3;
   localparam logic [PERIOD_WIDTH-1:0] RECOVERY_PERIOD_RESET  = 16'd60;

   localparam logic [MISS_WIDTH-1:0] MISS_SATURATED = '1;

   // Link state codes as seen on the result word.
   localparam logic [CODE_WIDTH-1:0] LINK_CODE_CONNECTING  = 2'd0;
   localparam logic [CODE_WIDTH-1:0] LINK_CODE_ESTABLISHED = 2'd1;
   localparam logic [CODE_WIDTH-1:0] LINK_CODE_UNREACHABLE = 2'd2;

   // Notification codes.
   localparam logic [CODE_WIDTH-1:0] EVENT_NONE        = 2'd0;
   localparam logic [CODE_WIDTH-1:0] EVENT_ESTABLISHED = 2'd1;
   localparam logic [CODE_WIDTH-1:0] EVENT_UNREACHABLE = 2'd2;

   typedef enum logic [2:0] {
      LINK_CONNECTING  = 3'b001,
      LINK_ESTABLISHED = 3'b010,
      LINK_UNREACHABLE = 3'b100
   } link_type;

   typedef struct packed {
      logic [PERIOD_WIDTH-1:0] keepalive_period;
      logic [PERIOD_WIDTH-1:0] receive_timeout;
      logic [MISS_WIDTH-1:0]   miss_limit;
      logic [PERIOD_WIDTH-1:0] recovery_period;
   } cfg_type;

   typedef struct packed {
      logic [TIME_WIDTH-1:0]  now_seconds;
      logic [COUNT_WIDTH-1:0] rx_packet_count;
      logic                   probe_ok;
   } req_type;

   typedef struct packed {
      logic [CODE_WIDTH-1:0] link_state;
      logic [CODE_WIDTH-1:0] notify_event;
      logic                  launch_probe;
      logic                  clear_probe_flag;
      logic                  monitor_stopped;
   } rsp_type;

   // A time plus a period is formed one bit wider so the sum never wraps.
   function automatic logic is_due(logic [TIME_WIDTH-1:0]   since,
                                   logic [PERIOD_WIDTH-1:0] period,
                                   logic [TIME_WIDTH-1:0]   now);
      logic [TIME_WIDTH:0] sum;
      sum = {1'b0, since} + {{(TIME_WIDTH-PERIOD_WIDTH+1){1'b0}}, period};
      return sum <= {1'b0, now};
   endfunction

   function automatic logic [CODE_WIDTH-1:0] link_code(link_type status);
      logic [CODE_WIDTH-1:0] code;
      unique case (status)
         LINK_ESTABLISHED: code = LINK_CODE_ESTABLISHED;
         LINK_UNREACHABLE: code = LINK_CODE_UNREACHABLE;
         default:          code = LINK_CODE_CONNECTING;
      endcase
      return code;
   endfunction

endpackage

@@ design/tkm_req_if.sv @@
// Tick channel of the tunnel keepalive monitor: valid, ready and one tick word.
// Depends on tkm_pkg for the field widths.
interface tkm_req_if;
   logic                            valid;
   logic                            ready;
   logic [tkm_pkg::TIME_WIDTH-1:0]  now_seconds;
   logic [tkm_pkg::COUNT_WIDTH-1:0] rx_packet_count;
   logic                            probe_ok;

   modport source (output valid, output now_seconds, output rx_packet_count,
                   output probe_ok, input ready);
   modport sink (input valid, input now_seconds, input rx_packet_count,
                 input probe_ok, output ready);
endinterface

@@ design/tkm_rsp_if.sv @@
// Result channel of the tunnel keepalive monitor: valid, ready and one result word.
// Depends on tkm_pkg for the field widths.
interface tkm_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [tkm_pkg::CODE_WIDTH-1:0] link_state;
   logic [tkm_pkg::CODE_WIDTH-1:0] notify_event;
   logic                           launch_probe;
   logic                           clear_probe_flag;
   logic                           monitor_stopped;

   modport source (output valid, output link_state, output notify_event,
                   output launch_probe, output clear_probe_flag,
                   output monitor_stopped, input ready);
   modport sink (input valid, input link_state, input notify_event,
                 input launch_probe, input clear_probe_flag,
                 input monitor_stopped, output ready);
endinterface

@@ design/tkm_csr_if.sv @@
// Configuration write channel of the tunnel keepalive monitor.
// Depends on tkm_pkg for the index and data widths.
interface tkm_csr_if;
   logic                                valid;
   logic                                ready;
   logic [tkm_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [tkm_pkg::CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/tkm_csr.sv @@
// Configuration registers of the tunnel keepalive monitor.
// Depends on tkm_pkg and tkm_csr_if.
module tkm_csr (
   input  logic             clock,
   input  logic             reset,
   tkm_csr_if.sink          csr_ch,
   output tkm_pkg::cfg_type cfg
);

   tkm_pkg::cfg_type cfg_ff;
   tkm_pkg::cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;
   assign cfg = cfg_ff;

   // Each register keeps only the low bits of its own width.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            tkm_pkg::CSR_KEEPALIVE_PERIOD: cfg_in.keepalive_period = csr_ch.data;
            tkm_pkg::CSR_RECEIVE_TIMEOUT:  cfg_in.receive_timeout  = csr_ch.data;
            tkm_pkg::CSR_MISS_LIMIT:
               cfg_in.miss_limit = csr_ch.data[tkm_pkg::MISS_WIDTH-1:0];
            tkm_pkg::CSR_RECOVERY_PERIOD:  cfg_in.recovery_period  = csr_ch.data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.keepalive_period <= tkm_pkg::KEEPALIVE_PERIOD_RESET;
         cfg_ff.receive_timeout  <= tkm_pkg::RECEIVE_TIMEOUT_RESET;
         cfg_ff.miss_limit       <= tkm_pkg::MISS_LIMIT_RESET;
         cfg_ff.recovery_period  <= tkm_pkg::RECOVERY_PERIOD_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ design/tkm_step.sv @@
// Link state, probe bookkeeping and the per-tick decision logic.
// Depends on tkm_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tkm_step (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  tkm_pkg::req_type tick,
   input  tkm_pkg::cfg_type cfg,
   output tkm_pkg::rsp_type result
);

   tkm_pkg::link_type                   status_ff, status_in;
   logic                                stopped_ff, stopped_in;
   logic [tkm_pkg::TIME_WIDTH-1:0]      probe_time_ff, probe_time_in;
   logic [tkm_pkg::TIME_WIDTH-1:0]      receive_time_ff, receive_time_in;
   logic [tkm_pkg::TIME_WIDTH-1:0]      recovery_time_ff, recovery_time_in;
   logic [tkm_pkg::COUNT_WIDTH-1:0]     prev_rx_ff, prev_rx_in;
   logic [tkm_pkg::MISS_WIDTH-1:0]      missed_ff, missed_in;
   logic [tkm_pkg::CODE_WIDTH-1:0]      event_code;
   logic                                launch;
   logic                                clear;
   logic                                probe_due;
   logic                                receive_due;
   logic                                recovery_due;

   assign probe_due    = tkm_pkg::is_due(probe_time_ff, cfg.keepalive_period,
                                         tick.now_seconds);
   assign receive_due  = tkm_pkg::is_due(receive_time_ff, cfg.receive_timeout,
                                         tick.now_seconds);
   assign recovery_due = tkm_pkg::is_due(recovery_time_ff, cfg.recovery_period,
                                         tick.now_seconds);

   always_comb begin
      status_in        = status_ff;
      stopped_in       = stopped_ff;
      probe_time_in    = probe_time_ff;
      receive_time_in  = receive_time_ff;
      recovery_time_in = recovery_time_ff;
      prev_rx_in       = prev_rx_ff;
      missed_in        = missed_ff;
      event_code       = tkm_pkg::EVENT_NONE;
      launch           = 1'b0;
      clear            = 1'b0;

      if (!stopped_ff) begin
         if (cfg.keepalive_period == '0) begin
            if (status_ff != tkm_pkg::LINK_ESTABLISHED) begin
               status_in  = tkm_pkg::LINK_ESTABLISHED;
               event_code = tkm_pkg::EVENT_ESTABLISHED;
            end
            stopped_in = 1'b1;
         end else if (status_ff != tkm_pkg::LINK_UNREACHABLE) begin
            if (probe_due) begin
               launch        = 1'b1;
               probe_time_in = tick.now_seconds;
               prev_rx_in    = tick.rx_packet_count;
               if (prev_rx_ff < tick.rx_packet_count) begin
                  // Counter growth since the last due tick proves the link alive.
                  if (status_ff != tkm_pkg::LINK_ESTABLISHED) begin
                     status_in  = tkm_pkg::LINK_ESTABLISHED;
                     event_code = tkm_pkg::EVENT_ESTABLISHED;
                  end
                  receive_time_in = tick.now_seconds;
               end else if (receive_due) begin
                  if (tick.probe_ok) begin
                     missed_in = '0;
                     if (status_ff != tkm_pkg::LINK_ESTABLISHED) begin
                        status_in  = tkm_pkg::LINK_ESTABLISHED;
                        event_code = tkm_pkg::EVENT_ESTABLISHED;
                     end
                  end else if (missed_ff != tkm_pkg::MISS_SATURATED) begin
                     missed_in = missed_ff + tkm_pkg::MISS_WIDTH'(1);
                  end
                  clear = 1'b1;
                  if (missed_in > cfg.miss_limit) begin
                     status_in  = tkm_pkg::LINK_UNREACHABLE;
                     event_code = tkm_pkg::EVENT_UNREACHABLE;
                  end
               end
            end
         end else if (recovery_due) begin
            // Recovery is silent: no notification and no flag clear.
            launch           = 1'b1;
            recovery_time_in = tick.now_seconds;
            if (tick.probe_ok) begin
               status_in = tkm_pkg::LINK_CONNECTING;
            end
         end
      end

      result.link_state       = tkm_pkg::link_code(status_in);
      result.notify_event     = event_code;
      result.launch_probe     = launch;
      result.clear_probe_flag = clear;
      result.monitor_stopped  = stopped_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff        <= tkm_pkg::LINK_CONNECTING;
         stopped_ff       <= 1'b0;
         probe_time_ff    <= '0;
         receive_time_ff  <= '0;
         recovery_time_ff <= '0;
         prev_rx_ff       <= '0;
         missed_ff        <= '0;
      end else if (fire) begin
         status_ff        <= status_in;
         stopped_ff       <= stopped_in;
         probe_time_ff    <= probe_time_in;
         receive_time_ff  <= receive_time_in;
         recovery_time_ff <= recovery_time_in;
         prev_rx_ff       <= prev_rx_in;
         missed_ff        <= missed_in;
      end
   end

   `TKM_ASSERT_NEXT(stop_is_final, clock, reset, stopped_ff, stopped_ff)
   `TKM_ASSERT_ALWAYS(stop_means_established, clock, reset,
      !stopped_ff || (status_ff == tkm_pkg::LINK_ESTABLISHED))
   `TKM_ASSERT_SAME(unreachable_from_judged_probe, clock, reset,
      fire && (result.notify_event == tkm_pkg::EVENT_UNREACHABLE),
      result.launch_probe && result.clear_probe_flag)

endmodule

@@ design/tunnel_keepalive_monitor.sv @@
// Top level of the tunnel keepalive monitor: tick register, decision logic, result register.
// Depends on tkm_pkg, the channel interfaces, tkm_csr and tkm_step.
//
// Returns exactly one result word per tick, in order. A tick is captured in an input
// register, judged by the decision logic against the stored link state, and its result
// lands in an output register; with the result side ready, one tick is accepted every
// cycle. The only loop is the stored link state, which updates in the same cycle as the
// result register loads. A result waiting on the output still lets one more tick into
// the input register; further ticks wait until that result word is taken.
// Configuration writes are always taken and should be made only while no tick is in flight.
module tunnel_keepalive_monitor (
   input  logic     clock,
   input  logic     reset,
   tkm_req_if.sink  req_ch,
   tkm_rsp_if.source rsp_ch,
   tkm_csr_if.sink  csr_ch
);

   tkm_pkg::cfg_type cfg;
   tkm_pkg::req_type tick_ff;
   tkm_pkg::rsp_type result;
   tkm_pkg::rsp_type result_ff;
   logic             tick_valid_ff;
   logic             result_valid_ff;
   logic             advance;

   // The held tick moves on whenever the output register is empty or being drained.
   assign advance      = tick_valid_ff && (!result_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !tick_valid_ff || advance;

   tkm_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   tkm_step u_step (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .tick   (tick_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         tick_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         tick_ff.now_seconds     <= req_ch.now_seconds;
         tick_ff.rx_packet_count <= req_ch.rx_packet_count;
         tick_ff.probe_ok        <= req_ch.probe_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         result_valid_ff <= 1'b0;
      end else if (advance) begin
         result_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         result_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_ch.valid            = result_valid_ff;
   assign rsp_ch.link_state       = result_ff.link_state;
   assign rsp_ch.notify_event     = result_ff.notify_event;
   assign rsp_ch.launch_probe     = result_ff.launch_probe;
   assign rsp_ch.clear_probe_flag = result_ff.clear_probe_flag;
   assign rsp_ch.monitor_stopped  = result_ff.monitor_stopped;

endmodule

@@ tb/tunnel_keepalive_monitor_test.sv @@
// Self-checking testbench of the tunnel keepalive monitor: a directed script with random ticks inside it.
// Every result word is checked against an in-bench tracker of the link state.
// Depends on tkm_pkg, the three channel interfaces and the tunnel_keepalive_monitor top level.
module tunnel_keepalive_monitor_test;
   timeunit 1ns;
   timeprecision 1ps;
   import tkm_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam logic [TIME_WIDTH-1:0] TIME_MAX = '1;

   typedef enum {ROW_TICK, ROW_RANDOM, ROW_DISABLE, ROW_REWRITE} row_kind_type;

   typedef struct {
      row_kind_type kind;
      req_type      tick;
      bit           typed;
      rsp_type      want;
   } script_row_type;

   typedef struct {
      rsp_type predicted;
      bit      typed;
      rsp_type listed;
   } pending_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tkm_req_if req_ch ();
   tkm_rsp_if rsp_ch ();
   tkm_csr_if csr_ch ();

   tunnel_keepalive_monitor u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Tracked link state and configuration.
   cfg_type                 live_cfg = '{KEEPALIVE_PERIOD_RESET, RECEIVE_TIMEOUT_RESET,
                                         MISS_LIMIT_RESET, RECOVERY_PERIOD_RESET};
   link_type                link_now = LINK_CONNECTING;
   bit                      halted = 1'b0;
   logic [TIME_WIDTH-1:0]   probe_time = '0;
   logic [TIME_WIDTH-1:0]   rx_time = '0;
   logic [TIME_WIDTH-1:0]   recovery_time = '0;
   logic [COUNT_WIDTH-1:0]  rx_prev = '0;
   logic [MISS_WIDTH-1:0]   misses = '0;

   pending_result_type pending_results [$];
   int unsigned        error_count = 0;
   int unsigned        idle_cycles = 0;
   bit                 tick_typed = 1'b0;
   rsp_type            tick_want = '0;

   logic [TIME_WIDTH-1:0]  now_cur = '0;
   logic [COUNT_WIDTH-1:0] rx_cur = '0;

   // Opening rows end at time 230 with the counter at its top value; the random phases
   // continue from there. The closing rows run time to its top value and then stop
   // monitoring for good, so they must come last.
   script_row_type script [0:22] = '{
      '{ROW_TICK, '{32'd0, 32'd0, 1'b0}, 1'b1,
        '{LINK_CODE_CONNECTING, EVENT_NONE, 1'b0, 1'b0, 1'b0}},
      '{ROW_TICK, '{32'd10, 32'd5, 1'b0}, 1'b1,
        '{LINK_CODE_ESTABLISHED, EVENT_ESTABLISHED, 1'b1, 1'b0, 1'b0}},
      '{ROW_TICK, '{32'd20, 32'd5, 1'b0}, 1'b1,
        '{LINK_CODE_ESTABLISHED, EVENT_NONE, 1'b1, 1'b0, 1'b0}},
      '{ROW_TICK, '{32'd40, 32'd5, 1'b1}, 1'b1,
        '{LINK_CODE_ESTABLISHED, EVENT_NONE, 1'b1, 1'b1, 1'b0}},
      '{ROW_TICK, '{32'd50, 32'd5, 1'b0}, 1'b1,
        '{LINK_CODE_ESTABLISHED, EVENT_NONE, 1'b1, 1'b1, 1'b0}},
      '{ROW_TICK, '{32'd60, 32'd5, 1'b0}, 1'b1,
        '{LINK_CODE_ESTABLISHED, EVENT_NONE, 1'b1, 1'b1, 1'b0}},
      '{ROW_TICK, '{32'd70, 32'd5, 1'b0}, 1'b1,
        '{LINK_CODE_ESTABLISHED, EVENT_NONE, 1'b1, 1'b1, 1'b0}},
      '{ROW_TICK, '{32'd80, 32'd5, 1'b0}, 1'b1,
        '{LINK_CODE_UNREACHABLE, EVENT_UNREACHABLE, 1'b1, 1'b1, 1'b0}},
      '{ROW_TICK, '{32'd85, 32'd5, 1'b0}, 1'b1,
        '{LINK_CODE_UNREACHABLE, EVENT_NONE, 1'b1, 1'b0, 1'b0}},
      '{ROW_TICK, '{32'd100, 32'd5, 1'b1}, 1'b1,
        '{LINK_CODE_UNREACHABLE, EVENT_NONE, 1'b0, 1'b0, 1'b0}},
      '{ROW_TICK, '{32'd145, 32'd5, 1'b1}, 1'b1,
        '{LINK_CODE_CONNECTING, EVENT_NONE, 1'b1, 1'b0, 1'b0}},
      '{ROW_TICK, '{32'd150, 32'd5, 1'b0}, 1'b1,
        '{LINK_CODE_UNREACHABLE, EVENT_UNREACHABLE, 1'b1, 1'b1, 1'b0}},
      '{ROW_TICK, '{32'd210, 32'd5, 1'b1}, 1'b1,
        '{LINK_CODE_CONNECTING, EVENT_NONE, 1'b1, 1'b0, 1'b0}},
      '{ROW_TICK, '{32'd220, 32'd4, 1'b1}, 1'b1,
        '{LINK_CODE_ESTABLISHED, EVENT_ESTABLISHED, 1'b1, 1'b1, 1'b0}},
      '{ROW_TICK, '{32'd230, 32'hFFFF_FFFF, 1'b0}, 1'b1,
        '{LINK_CODE_ESTABLISHED, EVENT_NONE, 1'b1, 1'b0, 1'b0}},
      '{ROW_RANDOM, '0, 1'b0, '0},
      '{ROW_TICK, '{TIME_MAX, 32'd0, 1'b0}, 1'b0, '0},
      '{ROW_TICK, '{TIME_MAX, 32'd0, 1'b1}, 1'b0, '0},
      '{ROW_DISABLE, '0, 1'b0, '0},
      '{ROW_TICK, '{TIME_MAX, 32'd1, 1'b1}, 1'b0, '0},
      '{ROW_TICK, '{TIME_MAX, 32'd2, 1'b0}, 1'b1,
        '{LINK_CODE_ESTABLISHED, EVENT_NONE, 1'b0, 1'b0, 1'b1}},
      '{ROW_REWRITE, '0, 1'b0, '0},
      '{ROW_TICK, '{TIME_MAX, 32'd3, 1'b1}, 1'b1,
        '{LINK_CODE_ESTABLISHED, EVENT_NONE, 1'b0, 1'b0, 1'b1}}
   };

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic bit period_elapsed(logic [TIME_WIDTH-1:0] since,
                                         logic [PERIOD_WIDTH-1:0] period,
                                         logic [TIME_WIDTH-1:0] now);
      logic [TIME_WIDTH:0] deadline;
      deadline = {1'b0, since} + (TIME_WIDTH + 1)'(period);
      return deadline <= {1'b0, now};
   endfunction

   // Advances the tracked link state by one tick and returns the result word it gives.
   function automatic rsp_type predict_tick(req_type t);
      rsp_type r;
      r = '0;
      r.notify_event = EVENT_NONE;
      if (!halted) begin
         if (live_cfg.keepalive_period == '0) begin
            if (link_now != LINK_ESTABLISHED) begin
               link_now = LINK_ESTABLISHED;
               r.notify_event = EVENT_ESTABLISHED;
            end
            halted = 1'b1;
         end else if (link_now != LINK_UNREACHABLE) begin
            if (period_elapsed(probe_time, live_cfg.keepalive_period, t.now_seconds)) begin
               r.launch_probe = 1'b1;
               probe_time = t.now_seconds;
               if (rx_prev < t.rx_packet_count) begin
                  if (link_now != LINK_ESTABLISHED) begin
                     link_now = LINK_ESTABLISHED;
                     r.notify_event = EVENT_ESTABLISHED;
                  end
                  rx_time = t.now_seconds;
               end else if (period_elapsed(rx_time, live_cfg.receive_timeout,
                                           t.now_seconds)) begin
                  if (t.probe_ok) begin
                     misses = '0;
                     if (link_now != LINK_ESTABLISHED) begin
                        link_now = LINK_ESTABLISHED;
                        r.notify_event = EVENT_ESTABLISHED;
                     end
                  end else if (misses != MISS_SATURATED) begin
                     misses = misses + MISS_WIDTH'(1);
                  end
                  r.clear_probe_flag = 1'b1;
                  if (misses > live_cfg.miss_limit) begin
                     link_now = LINK_UNREACHABLE;
                     r.notify_event = EVENT_UNREACHABLE;
                  end
               end
               rx_prev = t.rx_packet_count;
            end
         end else if (period_elapsed(recovery_time, live_cfg.recovery_period,
                                     t.now_seconds)) begin
            // Recovery is silent: no flag clear and no notification.
            r.launch_probe = 1'b1;
            recovery_time = t.now_seconds;
            if (t.probe_ok) begin
               link_now = LINK_CONNECTING;
            end
         end
      end
      case (link_now)
         LINK_ESTABLISHED: r.link_state = LINK_CODE_ESTABLISHED;
         LINK_UNREACHABLE: r.link_state = LINK_CODE_UNREACHABLE;
         default:          r.link_state = LINK_CODE_CONNECTING;
      endcase
      r.monitor_stopped = halted;
      return r;
   endfunction

   task automatic compare_result(rsp_type want, rsp_type got, string source);
      if (got.link_state !== want.link_state) begin
         $display("%0t: link_state (%s) expected %0d, got %0d", $time, source,
                  want.link_state, got.link_state);
         error_count++;
      end
      if (got.notify_event !== want.notify_event) begin
         $display("%0t: notify_event (%s) expected %0d, got %0d", $time, source,
                  want.notify_event, got.notify_event);
         error_count++;
      end
      if (got.launch_probe !== want.launch_probe) begin
         $display("%0t: launch_probe (%s) expected %0b, got %0b", $time, source,
                  want.launch_probe, got.launch_probe);
         error_count++;
      end
      if (got.clear_probe_flag !== want.clear_probe_flag) begin
         $display("%0t: clear_probe_flag (%s) expected %0b, got %0b", $time, source,
                  want.clear_probe_flag, got.clear_probe_flag);
         error_count++;
      end
      if (got.monitor_stopped !== want.monitor_stopped) begin
         $display("%0t: monitor_stopped (%s) expected %0b, got %0b", $time, source,
                  want.monitor_stopped, got.monitor_stopped);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      pending_result_type entry;
      rsp_type            got;
      bit                 moved;
      if (!reset) begin
         moved = 1'b0;
         if (csr_ch.valid && csr_ch.ready) begin
            moved = 1'b1;
            case (csr_ch.index)
               CSR_KEEPALIVE_PERIOD: live_cfg.keepalive_period = csr_ch.data;
               CSR_RECEIVE_TIMEOUT:  live_cfg.receive_timeout = csr_ch.data;
               CSR_MISS_LIMIT:       live_cfg.miss_limit = csr_ch.data[MISS_WIDTH-1:0];
               CSR_RECOVERY_PERIOD:  live_cfg.recovery_period = csr_ch.data;
               default: ;
            endcase
         end
         if (req_ch.valid && req_ch.ready) begin
            moved = 1'b1;
            entry.predicted = predict_tick('{req_ch.now_seconds, req_ch.rx_packet_count,
                                             req_ch.probe_ok});
            entry.typed = tick_typed;
            entry.listed = tick_want;
            pending_results.push_back(entry);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            moved = 1'b1;
            got = '{rsp_ch.link_state, rsp_ch.notify_event, rsp_ch.launch_probe,
                    rsp_ch.clear_probe_flag, rsp_ch.monitor_stopped};
            if (pending_results.size() == 0) begin
               $display("%0t: result word with no tick outstanding, got %h", $time, got);
               error_count++;
            end else begin
               entry = pending_results.pop_front();
               compare_result(entry.predicted, got, "tracker");
               if (entry.typed) begin
                  compare_result(entry.listed, got, "script");
               end
            end
         end
         if (moved) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
               $display("TB_ERROR");
               $finish;
            end
         end
      end
   end

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned gap_len();
      if ($urandom_range(0, 9) == 0) begin
         return $urandom_range(15, 60);
      end
      return $urandom_range(0, 3);
   endfunction

   initial begin : result_sink
      rsp_ch.ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 9) == 0) begin
            rsp_ch.ready = 1'b1;
            repeat ($urandom_range(50, 200)) @(negedge clock);
         end else begin
            int unsigned stall;
            stall = gap_len();
            if (stall > 0) begin
               rsp_ch.ready = 1'b0;
               repeat (stall) @(negedge clock);
            end
            rsp_ch.ready = 1'b1;
            repeat ($urandom_range(1, 4)) @(negedge clock);
         end
      end
   end

   task automatic send_tick(req_type t, int unsigned gap, bit typed, rsp_type want);
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid = 1'b1;
      req_ch.now_seconds = t.now_seconds;
      req_ch.rx_packet_count = t.rx_packet_count;
      req_ch.probe_ok = t.probe_ok;
      tick_typed = typed;
      tick_want = want;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
   endtask

   // Holds the tick side off until every result word is back, plus a short tail.
   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_WIDTH-1:0] index,
                            logic [CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_ch.valid = 1'b1;
      csr_ch.index = index;
      csr_ch.data = data;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
   endtask

   task automatic configure(logic [PERIOD_WIDTH-1:0] period, logic [PERIOD_WIDTH-1:0] timeout,
                            logic [MISS_WIDTH-1:0] limit, logic [PERIOD_WIDTH-1:0] recovery);
      logic [CSR_DATA_WIDTH-MISS_WIDTH-1:0] upper;
      // Junk above the miss limit's width must be dropped by the block.
      upper = (CSR_DATA_WIDTH - MISS_WIDTH)'($urandom());
      write_csr(CSR_KEEPALIVE_PERIOD, period);
      write_csr(CSR_RECEIVE_TIMEOUT, timeout);
      write_csr(CSR_MISS_LIMIT, {upper, limit});
      write_csr(CSR_RECOVERY_PERIOD, recovery);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   task automatic run_random_phases();
      logic [PERIOD_WIDTH-1:0] period, timeout, recovery;
      logic [MISS_WIDTH-1:0]   limit;
      int unsigned             step_min, step_max, ok_pct, count, pick;
      bit                      tight;
      req_type                 t;
      for (int p = 0; p < 8; p++) begin
         step_min = 0;
         case (p)
            0: begin
               period = 1; timeout = 0; limit = 0; recovery = 0;
               step_max = 2; ok_pct = 50; count = 80;
            end
            1: begin
               period = '1; timeout = '1; limit = MISS_SATURATED; recovery = '1;
               step_max = 40000; ok_pct = 50; count = 60;
            end
            2: begin
               // A probe judged every tick with the counter held: the miss count
               // runs into saturation and the link stays up.
               period = 1; timeout = 0; limit = MISS_SATURATED; recovery = 1;
               step_min = 1; step_max = 1; ok_pct = 0; count = 300;
            end
            3: begin
               period = 2; timeout = 3; limit = 3; recovery = 5;
               step_max = 4; ok_pct = 40; count = 80;
            end
            default: begin
               period = PERIOD_WIDTH'($urandom_range(1, 20));
               timeout = PERIOD_WIDTH'($urandom_range(0, 40));
               limit = MISS_WIDTH'($urandom_range(0, 6));
               recovery = PERIOD_WIDTH'($urandom_range(0, 40));
               step_max = 2 * period;
               ok_pct = $urandom_range(30, 80);
               count = 70;
            end
         endcase
         wait_drained();
         configure(period, timeout, limit, recovery);
         tight = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < count; i++) begin
            if (p == 3 && i == 40) begin
               wait_drained();
            end
            pick = $urandom_range(0, 9);
            if (p == 2) begin
               if (pick == 9) rx_cur = rx_cur - COUNT_WIDTH'(1);
            end else if (pick < 5) begin
               rx_cur = rx_cur + $urandom_range(1, 100);
            end else if (pick == 8) begin
               rx_cur = rx_cur - $urandom_range(1, 50);
            end else if (pick == 9) begin
               rx_cur = $urandom();
            end
            now_cur = now_cur + $urandom_range(step_min, step_max);
            t.now_seconds = now_cur;
            t.rx_packet_count = rx_cur;
            if (p == 2) begin
               // The first few ticks succeed so the phase starts out of the unreachable state.
               t.probe_ok = (i < 5);
            end else begin
               t.probe_ok = ($urandom_range(0, 99) < ok_pct);
            end
            send_tick(t, tight ? 0 : gap_len(), 1'b0, '0);
         end
      end
   endtask

   initial begin : stimulus
      req_ch.valid = 1'b0;
      req_ch.now_seconds = '0;
      req_ch.rx_packet_count = '0;
      req_ch.probe_ok = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = CSR_KEEPALIVE_PERIOD;
      csr_ch.data = '0;
      reset = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      now_cur = 32'd230;
      rx_cur = 32'hFFFF_FFFF;
      foreach (script[i]) begin
         case (script[i].kind)
            ROW_TICK:   send_tick(script[i].tick, gap_len(), script[i].typed, script[i].want);
            ROW_RANDOM: run_random_phases();
            ROW_DISABLE: begin
               wait_drained();
               configure('0, '1, MISS_SATURATED, '1);
            end
            ROW_REWRITE: begin
               // Monitoring is stopped for good, so new settings must have no effect.
               wait_drained();
               configure(KEEPALIVE_PERIOD_RESET, '0, '0, '0);
            end
            default: ;
         endcase
      end
      wait_drained();

      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+design
design/tkm_pkg.sv
design/tkm_req_if.sv
design/tkm_rsp_if.sv
design/tkm_csr_if.sv
design/tkm_csr.sv
design/tkm_step.sv
design/tunnel_keepalive_monitor.sv
tb/tunnel_keepalive_monitor_test.sv
